/* hdl/sspq_pkg.sv */
// Shared types and constants of the stable sorted priority queue.
// Used by sspq_ctrl, sspq_dpath and the top level; depends on nothing.
package sspq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_TOP   = 2'd2,
		CMD_PRINT = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		RES_ENTRY,
		RES_EMPTY,
		RES_FULL
	} res_sel_t;

	typedef struct packed {
		cmd_e_t             cmd;
		logic [15:0]        tag_in;
		logic signed [15:0] prio_in;
	} item_t;

	typedef struct packed {
		status_e_t          status;
		logic [15:0]        tag_out;
		logic signed [15:0] prio_out;
		logic               last;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic             capture;
		logic             do_push;
		logic             do_pop;
		logic             load_out;
		res_sel_t         sel;
		logic [IDX_W-1:0] rd_idx;
		logic             last;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		cmd_e_t           op;
		logic             empty;
		logic             full;
		logic [CNT_W-1:0] count;
	} dp_status_t;

endpackage

/* hdl/sspq_dpath.sv */
// Datapath of the stable sorted priority queue: sorted entry registers,
// fill count, captured operation and result register. Depends on sspq_pkg.
module sspq_dpath
	import sspq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	output result_t    result
);

	cmd_e_t             op_cmd_q;
	logic [15:0]        op_tag_q;
	logic signed [15:0] op_prio_q;

	logic [15:0]        ent_tag_q  [DEPTH];
	logic signed [15:0] ent_prio_q [DEPTH];
	logic [CNT_W-1:0]   fill_q;

	logic [15:0]        nxt_tag    [DEPTH];
	logic signed [15:0] nxt_prio   [DEPTH];
	logic [DEPTH-1:0]   keep;

	result_t            res_q;

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_cmd_q  <= item.cmd;
			op_tag_q  <= item.tag_in;
			op_prio_q <= item.prio_in;
		end
	end

	// Each cell decides locally: hold, take the new entry, or shift
	genvar g;
	for (g = 0; g < DEPTH; g++) begin : g_cell
		logic [15:0]        dn_tag;
		logic signed [15:0] dn_prio;
		logic [15:0]        up_tag;
		logic signed [15:0] up_prio;

		// An occupied entry of equal or higher priority stays ahead of the newcomer
		assign keep[g] = (CNT_W'(g) < fill_q) && (ent_prio_q[g] >= op_prio_q);

		if (g == 0) begin : g_head
			assign dn_tag  = op_tag_q;
			assign dn_prio = op_prio_q;
		end else begin : g_body
			assign dn_tag  = keep[g-1] ? op_tag_q  : ent_tag_q[g-1];
			assign dn_prio = keep[g-1] ? op_prio_q : ent_prio_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign up_tag  = ent_tag_q[g];
			assign up_prio = ent_prio_q[g];
		end else begin : g_inner
			assign up_tag  = ent_tag_q[g+1];
			assign up_prio = ent_prio_q[g+1];
		end

		assign nxt_tag[g]  = cmd.do_push ? (keep[g] ? ent_tag_q[g]  : dn_tag)  : up_tag;
		assign nxt_prio[g] = cmd.do_push ? (keep[g] ? ent_prio_q[g] : dn_prio) : up_prio;
	end

	always_ff @(posedge clk) begin
		if (cmd.do_push || cmd.do_pop) begin
			for (int i = 0; i < DEPTH; i++) begin
				ent_tag_q[i]  <= nxt_tag[i];
				ent_prio_q[i] <= nxt_prio[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.do_push) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (cmd.do_pop) begin
			fill_q <= fill_q - CNT_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q.last <= cmd.last;
			case (cmd.sel)
				RES_ENTRY: begin
					res_q.status   <= ST_OK;
					res_q.tag_out  <= ent_tag_q[cmd.rd_idx];
					res_q.prio_out <= ent_prio_q[cmd.rd_idx];
				end
				RES_EMPTY: begin
					res_q.status   <= ST_EMPTY;
					res_q.tag_out  <= '0;
					res_q.prio_out <= '0;
				end
				RES_FULL: begin
					res_q.status   <= ST_FULL;
					res_q.tag_out  <= '0;
					res_q.prio_out <= '0;
				end
				default: begin
					res_q.status   <= ST_EMPTY;
					res_q.tag_out  <= '0;
					res_q.prio_out <= '0;
				end
			endcase
		end
	end

	assign status.op    = op_cmd_q;
	assign status.count = fill_q;
	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == CNT_W'(DEPTH));
	assign result       = res_q;

endmodule

/* hdl/sspq_ctrl.sv */
// Controller of the stable sorted priority queue: sequences each command,
// walks the entries on print and owns the result valid. Depends on sspq_pkg.
module sspq_ctrl
	import sspq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	output logic       result_valid,
	input  logic       result_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_PRINT
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             res_valid_q;
	logic             out_free;

	assign out_free   = !res_valid_q || !result_stall;
	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.sel     = RES_ENTRY;
		cmd.rd_idx  = idx_q;
		cmd.capture = item_valid && (state_q == S_IDLE);
		state_d     = state_q;
		idx_d       = idx_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (status.op == CMD_PUSH) begin
					if (!status.full) begin
						cmd.do_push = 1'b1;
						state_d     = S_IDLE;
					end else if (out_free) begin
						cmd.load_out = 1'b1;
						cmd.sel      = RES_FULL;
						cmd.last     = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (status.empty) begin
					if (out_free) begin
						cmd.load_out = 1'b1;
						cmd.sel      = RES_EMPTY;
						cmd.last     = 1'b1;
						state_d      = S_IDLE;
					end
				end else if (status.op == CMD_POP) begin
					cmd.do_pop = 1'b1;
					state_d    = S_IDLE;
				end else if (out_free) begin
					// Top and the first entry of a print
					cmd.load_out = 1'b1;
					cmd.rd_idx   = '0;
					cmd.last     = (status.op == CMD_TOP) || (status.count == CNT_W'(1));
					if (cmd.last) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_PRINT;
						idx_d   = IDX_W'(1);
					end
				end
			end
			S_PRINT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.last     = (CNT_W'(idx_q) + CNT_W'(1)) == status.count;
					if (cmd.last) begin
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + IDX_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |-> !status.full)
		else $error("push into a full store");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_pop |=> (status.count == $past(status.count) - CNT_W'(1)))
		else $error("pop did not shrink the store by one");

	a_print_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PRINT) |-> (CNT_W'(idx_q) < status.count))
		else $error("print index past the last entry");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_stall) |-> !cmd.load_out)
		else $error("result register overwritten while stalled");
`endif

endmodule

/* hdl/stable_sorted_priority_queue.sv */
// Top level of the stable sorted priority queue.
// Joins sspq_ctrl and sspq_dpath; depends on sspq_pkg.
//
// Holds up to DEPTH (16) entries of a 16-bit tag and a signed 16-bit
// priority, sorted highest first; equal priorities leave in arrival order.
// Each transaction on the item channel carries push, pop, top or print.
// Push and pop give no result unless they fail: push into a full store gives
// one full result and the entry is dropped; pop, top or print on an empty
// store give one empty result. Top gives the head; print gives every entry
// from head to tail with last set on the final one. One item is worked on
// at a time: it is captured when accepted and executed in the execute state
// after it; print then sends the entries in turn, one a cycle while the
// result channel does not stall, through the single result register. Stall
// on the result channel stretches any command that has a result to deliver.
// The next item is accepted as soon as the last result sits in the result
// register, even while that result waits. Push compares the new priority
// with every entry at once and each entry cell shifts or holds by itself,
// so insertion needs no search loop. No clearing pass follows reset: the
// store is empty after reset and usable at once.
module stable_sorted_priority_queue
	import sspq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequence commands and hold the result handshake
	sspq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// Hold the sorted entries and drive the result payload
	sspq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

/* tb/tb_stable_sorted_priority_queue.sv */
// Self-checking testbench for the stable sorted priority queue.
// Drives transactions on the item channel and checks every result against its
// own model of the sorted store; depends on sspq_pkg and the RTL top level.
module tb_stable_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import sspq_pkg::*;

	localparam int RAND_ITEMS     = 434;
	localparam int PHASE_ITEMS    = 48;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;

	// One row of the directed table: the item, how often to issue it and,
	// where it is obvious, the single result it must give.
	typedef struct {
		item_t   it;
		int      reps;
		bit      typed;
		result_t want;
	} dir_row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Shadow of the sorted store, head at index 0
	logic [15:0]        shadow_tags  [DEPTH];
	logic signed [15:0] shadow_prios [DEPTH];
	int                 shadow_fill = 0;

	result_t  pending_results[$];
	dir_row_t dir_rows[$];
	int       mismatches = 0;
	bit       no_idle    = 1'b0;  // stretch in which neither side idles
	bit       valid_up   = 1'b0;  // item_valid is being held high

	always #2 clk = ~clk;

	stable_sorted_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	function automatic result_t make_result(status_e_t st, logic [15:0] tag,
			logic [15:0] prio, logic last);
		result_t r;
		r.status   = st;
		r.tag_out  = tag;
		r.prio_out = prio;
		r.last     = last;
		return r;
	endfunction

	// Apply one command to the shadow store and, if asked, queue the results
	// that it gives.
	function automatic void apply_queue_op(item_t it, bit keep);
		int pos;
		pos = 0;
		if (it.cmd == CMD_PUSH) begin
			if (shadow_fill >= DEPTH) begin
				if (keep) pending_results.push_back(make_result(ST_FULL, '0, '0, 1'b1));
				return;
			end
			// Stay behind every entry of equal or higher priority
			while (pos < shadow_fill && $signed(shadow_prios[pos]) >= $signed(it.prio_in))
				pos++;
			for (int i = shadow_fill; i > pos; i--) begin
				shadow_tags[i]  = shadow_tags[i - 1];
				shadow_prios[i] = shadow_prios[i - 1];
			end
			shadow_tags[pos]  = it.tag_in;
			shadow_prios[pos] = it.prio_in;
			shadow_fill++;
		end else if (shadow_fill == 0) begin
			if (keep) pending_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
		end else if (it.cmd == CMD_POP) begin
			for (int i = 1; i < shadow_fill; i++) begin
				shadow_tags[i - 1]  = shadow_tags[i];
				shadow_prios[i - 1] = shadow_prios[i];
			end
			shadow_fill--;
		end else if (it.cmd == CMD_TOP) begin
			if (keep)
				pending_results.push_back(make_result(ST_OK, shadow_tags[0],
					shadow_prios[0], 1'b1));
		end else begin
			for (int i = 0; i < shadow_fill; i++)
				if (keep)
					pending_results.push_back(make_result(ST_OK, shadow_tags[i],
						shadow_prios[i], i == shadow_fill - 1));
		end
	endfunction

	// Idle length for either side: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Bias 0 fills the store, 1 drains it, anything else keeps it balanced.
	// Priorities cluster round zero so that ties are common.
	function automatic item_t rand_item(int bias);
		item_t it;
		int    r;
		int    push_w;
		int    pop_w;
		case (bias)
			0: begin
				push_w = 65;
				pop_w  = 15;
			end
			1: begin
				push_w = 20;
				pop_w  = 55;
			end
			default: begin
				push_w = 40;
				pop_w  = 38;
			end
		endcase
		r = $urandom_range(0, 99);
		if (r < push_w)
			it.cmd = CMD_PUSH;
		else if (r < push_w + pop_w)
			it.cmd = CMD_POP;
		else if (r < 92)
			it.cmd = CMD_TOP;
		else
			it.cmd = CMD_PRINT;
		it.tag_in = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (r < 50)
			it.prio_in = 16'(int'($urandom_range(0, 6)) - 3);
		else if (r < 60) begin
			case ($urandom_range(0, 3))
				0:       it.prio_in = 16'sh7FFF;
				1:       it.prio_in = 16'sh8000;
				2:       it.prio_in = 16'sh0000;
				default: it.prio_in = 16'shFFFF;
			endcase
		end else
			it.prio_in = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic void add_row(cmd_e_t cmd, logic [15:0] tag, logic [15:0] prio,
			int reps, bit typed, result_t want);
		dir_row_t row;
		row.it.cmd     = cmd;
		row.it.tag_in  = tag;
		row.it.prio_in = prio;
		row.reps       = reps;
		row.typed      = typed;
		row.want       = want;
		dir_rows.push_back(row);
	endfunction

	// Offer one transaction, hold it until taken, then book its results.
	// Valid stays high into the next item unless a gap is drawn.
	task automatic send_item(item_t it, bit typed, result_t want);
		int gap;
		item       <= it;
		item_valid <= 1'b1;
		valid_up    = 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		apply_queue_op(it, !typed);
		if (typed)
			pending_results.push_back(want);
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			valid_up    = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every booked result has come, then let the block
	// finish any push or pop still in flight.
	task automatic wait_for_drain();
		if (valid_up) begin
			item_valid <= 1'b0;
			valid_up    = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: stall in bursts of random length, with quiet runs between
	initial begin : result_stall_driver
		int run;
		@(posedge clk);
		forever begin
			run = pick_gap();
			if (run > 0) begin
				result_stall <= 1'b1;
				repeat (run) @(posedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Compare each delivered result, field by field, with the oldest booked one
	always @(posedge clk) begin : result_checker
		result_t want;
		if (arst_n && result_valid === 1'b1 && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: status %0d tag %h prio %0d last %b",
						result.status, result.tag_out, result.prio_out, result.last);
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status || result.tag_out !== want.tag_out ||
						result.prio_out !== want.prio_out || result.last !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("expected %0d %h %0d %b, got %0d %h %0d %b",
							want.status, want.tag_out, want.prio_out, want.last,
							result.status, result.tag_out, result.prio_out, result.last);
				end
			end
		end
	end

	// Abort when neither channel has moved a transaction for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) ||
					(result_valid === 1'b1 && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		dir_row_t row;
		item_t    it;
		result_t  none;
		result_t  empty_res;
		result_t  full_res;
		int       bias;
		none      = '0;
		empty_res = make_result(ST_EMPTY, '0, '0, 1'b1);
		full_res  = make_result(ST_FULL, '0, '0, 1'b1);
		bias      = 2;

		// Empty store: every command but push reports empty
		add_row(CMD_POP,   16'h0000, 16'h0000, 1, 1'b1, empty_res);
		add_row(CMD_TOP,   16'h0000, 16'h0000, 1, 1'b1, empty_res);
		add_row(CMD_PRINT, 16'h0000, 16'h0000, 1, 1'b1, empty_res);
		// Extremes of tag and priority; a tie at the top must stay behind
		add_row(CMD_PUSH,  16'hFFFF, 16'h7FFF, 1, 1'b0, none);
		add_row(CMD_TOP,   16'h0000, 16'h0000, 1, 1'b1,
			make_result(ST_OK, 16'hFFFF, 16'h7FFF, 1'b1));
		add_row(CMD_PUSH,  16'h0000, 16'h8000, 1, 1'b0, none);
		add_row(CMD_PUSH,  16'h1234, 16'h7FFF, 1, 1'b0, none);
		add_row(CMD_PUSH,  16'hAAAA, 16'h0000, 1, 1'b0, none);
		add_row(CMD_PUSH,  16'h5555, 16'hFFFF, 1, 1'b0, none);
		add_row(CMD_PRINT, 16'h0000, 16'h0000, 1, 1'b0, none);
		add_row(CMD_POP,   16'h0000, 16'h0000, 1, 1'b0, none);
		add_row(CMD_TOP,   16'h0000, 16'h0000, 1, 1'b0, none);
		// Fill with equal priorities, overflow once, then print a full store
		add_row(CMD_PUSH,  16'h0100, 16'h0005, 12, 1'b0, none);
		add_row(CMD_PUSH,  16'hBEEF, 16'h7FFF, 1, 1'b1, full_res);
		add_row(CMD_PRINT, 16'h0000, 16'h0000, 1, 1'b0, none);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			for (int n = 0; n < row.reps; n++) begin
				it = row.it;
				// Step the tag so repeated pushes stay distinguishable
				it.tag_in = row.it.tag_in + 16'(n);
				send_item(it, row.typed, row.want);
			end
		end
		wait_for_drain();

		// Random part: phases that fill, drain or balance the store, some of
		// them with no idling on either side
		for (int k = 0; k < RAND_ITEMS; k++) begin
			if (k % PHASE_ITEMS == 0) begin
				bias    = $urandom_range(0, 2);
				no_idle = ($urandom_range(0, 3) == 0);
			end
			if (k == RAND_ITEMS / 2)
				wait_for_drain();
			send_item(rand_item(bias), 1'b0, none);
		end
		no_idle = 1'b0;
		wait_for_drain();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
